>>> sv/b64lw_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the character lookup for the line-wrapping base64 encoder
// no dependencies
package b64lw_pkg;

	localparam int unsigned LINE_LEN_W = 10;
	localparam logic [LINE_LEN_W-1:0] LINE_LENGTH_RESET = 10'd76;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] PAD_CHAR = 8'd61;

	// work record for one input byte, passed from front to back
	typedef struct packed {
		logic [5:0] sextet0;
		logic [5:0] sextet1;
		logic       has_closing;
		logic [1:0] pad_count;
		logic       final_byte;
	} b64lw_rec_t;

	// one output character with its flags
	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       end_of_message;
	} b64lw_out_t;

	// standard base64 alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] v;
		v = {2'b00, s};
		if (s < 6'd26) begin
			return v + 8'd65;
		end else if (s < 6'd52) begin
			return v + 8'd71;
		end else if (s < 6'd62) begin
			return v - 8'd4;
		end else if (s == 6'd62) begin
			return 8'd43;
		end else begin
			return 8'd47;
		end
	endfunction

endpackage

>>> sv/base64_line_wrap_encoder_top.sv
`timescale 1ns / 1ps
// top level of the line-wrapping base64 encoder
// depends on b64lw_pkg, b64lw_fifo, b64lw_front, b64lw_back
//
// input side is a queue: drive data_byte/final_byte with push, a transfer
// happens when push is high and full is low. final_byte closes the message,
// adds '=' pads and starts the next byte on a fresh line.
// result side is a queue: out_char/last_of_run/end_of_message are valid while
// empty is low, and a transfer happens when pop is high and empty is low.
// line_length is set through cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. each
// byte turns into 1 to 4 characters plus up to two newlines, at most 6
// results; the back part emits one character per cycle while a record waits
// and the result queue has room. the first character of a byte goes through
// the record queue, then the result queue, before it is on the result ports.
// a two-entry record queue parts front from back, and a two-entry result
// queue parts back from the receiver: when pop stays low both fill, then
// full goes high; nothing is lost.
// reset clears phase, carry, column, both queues, and sets line_length to 76.
module base64_line_wrap_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       end_of_message,
	input  logic       cfg_we,
	input  logic [9:0] cfg_data
);
	import b64lw_pkg::*;

	logic [9:0]  line_length_q;
	b64lw_rec_t  front_rec;
	b64lw_rec_t  back_rec;
	logic        rec_empty;
	logic        rec_pop;
	logic        accept;
	logic        out_full;
	logic        out_push;
	b64lw_out_t  back_out;
	b64lw_out_t  head_out;

	assign accept = push && !full;

	// line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
		end else if (cfg_we) begin
			line_length_q <= cfg_data;
		end
	end

	// front: phase tracking
	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.rec        (front_rec)
	);

	// record queue between front and back
	b64lw_fifo #(
		.WIDTH($bits(b64lw_rec_t))
	) u_rec_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_rec),
		.full    (full),
		.rd_en   (rec_pop),
		.rd_data (back_rec),
		.empty   (rec_empty)
	);

	// back: character sequencing
	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (line_length_q),
		.rec         (back_rec),
		.rec_valid   (!rec_empty),
		.rec_pop     (rec_pop),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_item    (back_out)
	);

	// result queue
	b64lw_fifo #(
		.WIDTH($bits(b64lw_out_t))
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (back_out),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (head_out),
		.empty   (empty)
	);

	assign out_char       = head_out.out_char;
	assign last_of_run    = head_out.last_of_run;
	assign end_of_message = head_out.end_of_message;

endmodule

>>> sv/b64lw_fifo.sv
`timescale 1ns / 1ps
// two-entry register queue used between front and back and on the result side
// no package dependencies
module b64lw_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/b64lw_front.sv
`timescale 1ns / 1ps
// front part: tracks group phase and carry bits, builds one work record per byte
// depends on b64lw_pkg
module b64lw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output b64lw_pkg::b64lw_rec_t rec
);
	import b64lw_pkg::*;

	// position of the next byte within its group
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	phase_t     phase_q;
	logic [3:0] carry_q;
	logic [3:0] carry_nxt;

	// split the byte by phase
	always_comb begin
		rec.final_byte = final_byte;
		case (phase_q)
			PH_SECOND: begin
				rec.sextet0     = {carry_q[1:0], data_byte[7:4]};
				rec.sextet1     = {data_byte[3:0], 2'b00};
				rec.has_closing = final_byte;
				rec.pad_count   = final_byte ? 2'd1 : 2'd0;
				carry_nxt       = data_byte[3:0];
			end
			PH_THIRD: begin
				rec.sextet0     = {carry_q, data_byte[7:6]};
				rec.sextet1     = data_byte[5:0];
				rec.has_closing = 1'b1;
				rec.pad_count   = 2'd0;
				carry_nxt       = 4'd0;
			end
			default: begin
				rec.sextet0     = data_byte[7:2];
				rec.sextet1     = {data_byte[1:0], 4'b0000};
				rec.has_closing = final_byte;
				rec.pad_count   = final_byte ? 2'd2 : 2'd0;
				carry_nxt       = {2'b00, data_byte[1:0]};
			end
		endcase
	end

	// phase and carry update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 4'd0;
		end else if (accept) begin
			if (final_byte || phase_q == PH_THIRD) begin
				phase_q <= PH_FIRST;
			end else if (phase_q == PH_SECOND) begin
				phase_q <= PH_THIRD;
			end else begin
				phase_q <= PH_SECOND;
			end
			carry_q <= final_byte ? 4'd0 : carry_nxt;
		end
	end

endmodule

>>> sv/b64lw_back.sv
`timescale 1ns / 1ps
// back part: walks each work record one character per cycle while the result queue has room, inserts newlines
// depends on b64lw_pkg
module b64lw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [9:0]            line_length,
	input  b64lw_pkg::b64lw_rec_t rec,
	input  logic                  rec_valid,
	output logic                  rec_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output b64lw_pkg::b64lw_out_t out_item
);
	import b64lw_pkg::*;

	// character slot within one work record
	typedef enum logic [1:0] {
		ST_DATA0 = 2'd0,
		ST_DATA1 = 2'd1,
		ST_PAD0  = 2'd2,
		ST_PAD1  = 2'd3
	} step_t;

	step_t      step_q;
	logic       nl_done_q;
	logic [9:0] col_q;
	logic       is_data;
	logic       need_nl;
	logic       is_last;
	logic       fire;
	logic [5:0] sextet;

	// decide the next character
	always_comb begin
		is_data = (step_q == ST_DATA0) || (step_q == ST_DATA1);
		sextet  = (step_q == ST_DATA0) ? rec.sextet0 : rec.sextet1;
		need_nl = is_data && (col_q >= line_length) && !nl_done_q;
		case (step_q)
			ST_DATA0: is_last = !rec.has_closing;
			ST_DATA1: is_last = (rec.pad_count == 2'd0);
			ST_PAD0:  is_last = (rec.pad_count == 2'd1);
			default:  is_last = 1'b1;
		endcase
		fire    = rec_valid && !out_full;
		out_push = fire;
		rec_pop  = fire && !need_nl && is_last;
		if (need_nl) begin
			out_item.out_char = NEWLINE_CHAR;
		end else if (is_data) begin
			out_item.out_char = b64_char(sextet);
		end else begin
			out_item.out_char = PAD_CHAR;
		end
		out_item.last_of_run    = !need_nl && is_last;
		out_item.end_of_message = !need_nl && is_last && rec.final_byte;
	end

	// step, column and newline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_DATA0;
			nl_done_q <= 1'b0;
			col_q     <= 10'd0;
		end else if (fire) begin
			if (need_nl) begin
				nl_done_q <= 1'b1;
				col_q     <= 10'd0;
			end else begin
				nl_done_q <= 1'b0;
				if (is_last) begin
					step_q <= ST_DATA0;
					col_q  <= rec.final_byte ? 10'd0 : col_q + 10'd1;
				end else begin
					case (step_q)
						ST_DATA0: step_q <= ST_DATA1;
						ST_DATA1: step_q <= ST_PAD0;
						default:  step_q <= ST_PAD1;
					endcase
					col_q  <= col_q + 10'd1;
				end
			end
		end
	end

endmodule

>>> test/base64_line_wrap_encoder_checker.sv
`timescale 1ns / 1ps
// checker for the line-wrapping base64 encoder: predicts the characters of every accepted byte
// and compares each result transfer against the oldest prediction; depends on b64lw_pkg
module base64_line_wrap_encoder_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic [7:0]                       data_byte,
	input  logic                             final_byte,
	input  logic                             pop,
	input  logic                             empty,
	input  logic [7:0]                       out_char,
	input  logic                             last_of_run,
	input  logic                             end_of_message,
	input  logic                             cfg_we,
	input  logic [b64lw_pkg::LINE_LEN_W-1:0] cfg_data,
	output int                               mismatches,
	output int                               outstanding,
	output int                               compared
);
	import b64lw_pkg::*;

	// position of the next byte within its three-byte group
	typedef enum logic [1:0] {
		GRP_FIRST  = 2'd0,
		GRP_SECOND = 2'd1,
		GRP_THIRD  = 2'd2
	} grp_pos_t;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// predictor state
	logic [LINE_LEN_W-1:0] line_len;
	grp_pos_t              grp_pos;
	logic [3:0]            carry;
	logic [LINE_LEN_W-1:0] column;

	// predicted characters, oldest first, and the run of the byte being encoded
	b64lw_out_t char_queue[$];
	b64lw_out_t byte_run[$];
	b64lw_out_t got;
	b64lw_out_t want;
	int         err_count;
	int         checked;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		int idx;
		idx = 63 - int'(s);
		return ALPHABET[8*idx +: 8];
	endfunction

	task automatic add_char(input logic [7:0] c);
		b64lw_out_t e;
		e.out_char = c;
		e.last_of_run = 1'b0;
		e.end_of_message = 1'b0;
		byte_run.push_back(e);
	endtask

	// data character, wrapping first if the line is already full
	task automatic add_data(input logic [5:0] s);
		if (column >= line_len) begin
			add_char(NEWLINE_CHAR);
			column = '0;
		end
		add_char(sextet_char(s));
		column = column + 1'b1;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		grp_pos_t   pos;
		b64lw_out_t tail;
		pos = grp_pos;
		byte_run.delete();
		// leading sextet from carried bits and the high bits of this byte
		case (pos)
			GRP_FIRST: begin
				add_data(b[7:2]);
				carry = {2'b00, b[1:0]};
			end
			GRP_SECOND: begin
				add_data({carry[1:0], b[7:4]});
				carry = b[3:0];
			end
			default: begin
				add_data({carry, b[7:6]});
				carry = '0;
			end
		endcase
		// closing sextet at the end of a group or of the message
		if (pos == GRP_THIRD || fin) begin
			case (pos)
				GRP_FIRST: begin
					add_data({b[1:0], 4'b0000});
				end
				GRP_SECOND: begin
					add_data({b[3:0], 2'b00});
				end
				default: begin
					add_data(b[5:0]);
				end
			endcase
		end
		// pads never wrap; a finished message restarts on a fresh line
		if (fin) begin
			if (pos == GRP_FIRST) begin
				add_char(PAD_CHAR);
				add_char(PAD_CHAR);
			end else if (pos == GRP_SECOND) begin
				add_char(PAD_CHAR);
			end
			grp_pos = GRP_FIRST;
			carry = '0;
			column = '0;
		end else begin
			grp_pos = (pos == GRP_FIRST) ? GRP_SECOND :
				(pos == GRP_SECOND) ? GRP_THIRD : GRP_FIRST;
		end
		tail = byte_run.pop_back();
		tail.last_of_run = 1'b1;
		tail.end_of_message = fin;
		byte_run.push_back(tail);
		foreach (byte_run[i]) char_queue.push_back(byte_run[i]);
	endtask

	// watch config, input and result transfers at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len = LINE_LENGTH_RESET;
			grp_pos = GRP_FIRST;
			carry = '0;
			column = '0;
			char_queue.delete();
			err_count = 0;
			checked = 0;
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			if (cfg_we) begin
				line_len = cfg_data;
			end
			if (push && !full) begin
				encode_byte(data_byte, final_byte);
			end
			if (pop && !empty) begin
				got = {out_char, last_of_run, end_of_message};
				if (char_queue.size() == 0) begin
					err_count++;
					if (err_count <= 10) begin
						$display("unexpected character %0d (last %b, end %b), none predicted",
							got.out_char, got.last_of_run, got.end_of_message);
					end
				end else begin
					want = char_queue.pop_front();
					checked++;
					if (got !== want) begin
						err_count++;
						if (err_count <= 10) begin
							$display("char #%0d: expected %0d last %b end %b, got %0d last %b end %b",
								checked, want.out_char, want.last_of_run, want.end_of_message,
								got.out_char, got.last_of_run, got.end_of_message);
						end
					end
				end
			end
			mismatches <= err_count;
			outstanding <= char_queue.size();
			compared <= checked;
		end
	end

endmodule

>>> test/base64_line_wrap_encoder_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the line-wrapping base64 encoder: drives bytes, pops and line lengths
// depends on b64lw_pkg, base64_line_wrap_encoder_top and base64_line_wrap_encoder_checker
module base64_line_wrap_encoder_top_tb;
	import b64lw_pkg::*;

	// longest quiet stretch of a correct run is a random input gap or result
	// stall plus the delay through both queues, so this is far beyond it
	localparam int STALL_LIMIT = 1000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            data_byte = '0;
	logic                  final_byte = 1'b0;
	logic                  pop = 1'b0;
	logic                  empty;
	logic [7:0]            out_char;
	logic                  last_of_run;
	logic                  end_of_message;
	logic                  cfg_we = 1'b0;
	logic [LINE_LEN_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int compared;
	int bytes_sent = 0;
	int messages_sent = 0;
	int idle_cycles = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b1;
	logic [LINE_LEN_W-1:0] spot_len;

	base64_line_wrap_encoder_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.final_byte     (final_byte),
		.pop            (pop),
		.empty          (empty),
		.out_char       (out_char),
		.last_of_run    (last_of_run),
		.end_of_message (end_of_message),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data)
	);

	base64_line_wrap_encoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.final_byte     (final_byte),
		.pop            (pop),
		.empty          (empty),
		.out_char       (out_char),
		.last_of_run    (last_of_run),
		.end_of_message (end_of_message),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.compared       (compared)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one byte transfer, with an optional gap before it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
		if (fin) messages_sent++;
	endtask

	// hold the input side until every predicted character has been popped
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_line_length(input logic [LINE_LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// messages of random length and content; the last one may stay open
	task automatic send_stream(input int count, input bit leave_open);
		int         left;
		logic [7:0] b;
		logic       fin;
		left = $urandom_range(1, 12);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			if (i == count - 1) begin
				fin = !leave_open;
			end else begin
				fin = (left == 1);
			end
			send_byte(b, fin);
			left = fin ? $urandom_range(1, 12) : left - 1;
			// occasionally let the block run completely dry mid-stream
			if ($urandom_range(0, 39) == 0) begin
				wait_drained();
			end
		end
	endtask

	// result side: pop with random stall bursts
	initial begin : result_side
		int n;
		forever begin
			if (rx_stalls && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("base64_line_wrap_encoder_top_tb NOT OK");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset line length: pads of every group position, byte extremes,
		// the '+' and '/' characters
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		wait_drained();

		// one character per line: newline before every data character but the first of a message, not pads
		write_line_length(10'd1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		wait_drained();

		// zero length puts a newline before every data character, even the first
		write_line_length(10'd0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h7E, 1'b1);
		wait_drained();

		// random phases; odd phases leave a message open so the next,
		// shorter length lands in the middle of a line
		spot_len = 10'($urandom_range(3, 40));
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_line_length(10'd1023);
				end
				1: begin
					write_line_length(10'd76);
				end
				2: begin
					write_line_length(10'd7);
				end
				3: begin
					write_line_length(10'd2);
				end
				4: begin
					write_line_length(10'd1);
				end
				default: begin
					write_line_length(spot_len);
				end
			endcase
			if (p == 5) begin
				tx_gaps = 1'b0;
				rx_stalls = 1'b0;
			end else begin
				tx_gaps = (p == 0) || ($urandom_range(0, 3) != 0);
				rx_stalls = (p == 0) || ($urandom_range(0, 3) != 0);
			end
			send_stream(20, (p % 2) == 1);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		$display("sent %0d bytes in %0d closed messages at line lengths 76, 0, 1, 2, 7, 1023, %0d",
			bytes_sent, messages_sent, spot_len);
		$display("compared %0d characters, %0d mismatches", compared, mismatches);
		if (mismatches == 0) begin
			$display("base64_line_wrap_encoder_top_tb OK");
		end else begin
			$display("base64_line_wrap_encoder_top_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> base64_line_wrap_encoder_top.f
sv/b64lw_pkg.sv
sv/b64lw_fifo.sv
sv/b64lw_front.sv
sv/b64lw_back.sv
sv/base64_line_wrap_encoder_top.sv
test/base64_line_wrap_encoder_checker.sv
test/base64_line_wrap_encoder_top_tb.sv
